// File: sv/channel_activity_detector_macros.svh
// Assertion macros used by the checker file.
`ifndef CHANNEL_ACTIVITY_DETECTOR_MACROS_SVH
`define CHANNEL_ACTIVITY_DETECTOR_MACROS_SVH

// Checked at every clock edge outside of reset.
`define CAD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("channel activity detector assertion failed");

// Checked at every clock edge, reset included.
`define CAD_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("channel activity detector reset assertion failed");

`endif

// File: sv/cad_pkg.sv
package cad_pkg;

   localparam int WORD_W      = 16;
   localparam int POWER_W     = 32;
   localparam int ENERGY_W    = 40;
   localparam int PROD_W      = ENERGY_W + WORD_W;
   localparam int CSR_INDEX_W = 8;

   localparam int WORK_DEPTH  = 4;
   localparam int WORK_PTR_W  = 2;
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = 3;

   localparam logic [2:0] EV_IDLE        = 3'd0;
   localparam logic [2:0] EV_ACTIVATED   = 3'd1;
   localparam logic [2:0] EV_DEACTIVATED = 3'd2;
   localparam logic [2:0] EV_APPEND      = 3'd3;
   localparam logic [2:0] EV_PARTIAL     = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD_RATIO = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_BLOCKS      = 8'd1;

   localparam logic [WORD_W-1:0] THRESHOLD_RESET  = 16'd511;
   localparam logic [WORD_W-1:0] MAX_BLOCKS_RESET = 16'd16;

   typedef struct packed {
      logic [2:0]         channel_id;
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
      logic               last_bin;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  out_channel;
      logic [2:0]  event_res;
      logic [15:0] part_number;
      logic [15:0] activation_count;
      logic [15:0] flushed_blocks;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]         channel;
      logic [POWER_W-1:0] power;
      logic               last_bin;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } work_head_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_write_type;

endpackage

// File: sv/channel_activity_detector.sv
// Channel   Direction  Handshake             Payload
// req       in         push / full           req_item (channel, sample, last bin)
// rsp       out        pop / empty           rsp_item (decision of one window)
// csr       in         csr_valid / csr_ready csr_index, csr_data
//
// One bin sample is accepted every clock while the input queue has room.
// A decision for a window passes energy accumulate, ratio multiply, then decision
// and result queue write after its closing bin leaves the input queue.
// The result queue holds eight decisions and decisions in flight reserve a place;
// when no place is left the back end stops taking work, the input queue fills
// and full rises. Reset is synchronous and sets all channel state at once.
module channel_activity_detector #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  cad_pkg::req_item_type              req_item,
   output logic                               empty,
   input  logic                               pop,
   output cad_pkg::rsp_item_type              rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cad_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cad_pkg::WORD_W-1:0]         csr_data
);

   cad_pkg::work_head_type          head;
   logic                            work_pop;
   cad_pkg::rsp_write_type          rsp_write;
   logic [cad_pkg::RSP_PTR_W:0]     rsp_level;
   logic [cad_pkg::WORD_W-1:0]      threshold_ff;
   logic [cad_pkg::WORD_W-1:0]      max_blocks_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= cad_pkg::THRESHOLD_RESET;
         max_blocks_ff <= cad_pkg::MAX_BLOCKS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == cad_pkg::REG_THRESHOLD_RATIO) begin
            threshold_ff <= csr_data;
         end
         if (csr_index == cad_pkg::REG_MAX_BLOCKS) begin
            max_blocks_ff <= csr_data;
         end
      end
   end

   cad_front #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_item (req_item),
      .full     (full),
      .work_pop (work_pop),
      .head     (head)
   );

   cad_back #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .work_pop        (work_pop),
      .threshold_ratio (threshold_ff),
      .max_blocks      (max_blocks_ff),
      .rsp_level       (rsp_level),
      .rsp_write       (rsp_write)
   );

   cad_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_write (rsp_write),
      .pop       (pop),
      .empty     (empty),
      .rsp_item  (rsp_item),
      .level     (rsp_level)
   );

endmodule

// File: sv/cad_front.sv
module cad_front #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cad_pkg::req_item_type req_item,
   output logic                  full,
   input  logic                  work_pop,
   output cad_pkg::work_head_type head
);

   logic signed [31:0]                 re_sq;
   logic signed [31:0]                 im_sq;
   cad_pkg::work_type                  work_in;
   logic                               channel_ok;
   logic                               write_en;
   cad_pkg::work_type                  queue_ff [cad_pkg::WORK_DEPTH];
   logic [cad_pkg::WORK_PTR_W-1:0]     wr_ptr_ff;
   logic [cad_pkg::WORK_PTR_W-1:0]     rd_ptr_ff;
   logic [cad_pkg::WORK_PTR_W:0]       count_ff;
   logic [cad_pkg::WORK_PTR_W:0]       count_in;

   assign re_sq = 32'(req_item.sample_re) * 32'(req_item.sample_re);
   assign im_sq = 32'(req_item.sample_im) * 32'(req_item.sample_im);

   assign channel_ok = int'(req_item.channel_id) < NUM_CHANNELS;

   always_comb begin
      work_in.channel  = req_item.channel_id;
      work_in.power    = unsigned'(re_sq) + unsigned'(im_sq);
      work_in.last_bin = req_item.last_bin;
   end

   assign full     = count_ff == (cad_pkg::WORK_PTR_W + 1)'(cad_pkg::WORK_DEPTH);
   assign write_en = push && !full && channel_ok;

   always_comb begin
      count_in = count_ff;
      if (write_en && !work_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!write_en && work_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (write_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (work_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         queue_ff[wr_ptr_ff] <= work_in;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.work  = queue_ff[rd_ptr_ff];

endmodule

// File: sv/cad_back.sv
module cad_back #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cad_pkg::work_head_type         head,
   output logic                           work_pop,
   input  logic [cad_pkg::WORD_W-1:0]     threshold_ratio,
   input  logic [cad_pkg::WORD_W-1:0]     max_blocks,
   input  logic [cad_pkg::RSP_PTR_W:0]    rsp_level,
   output cad_pkg::rsp_write_type         rsp_write
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int E_W  = cad_pkg::ENERGY_W;
   localparam int P_W  = cad_pkg::PROD_W;
   localparam int W_W  = cad_pkg::WORD_W;

   logic [E_W-1:0]  energy_ff   [NUM_CHANNELS];
   logic [E_W-1:0]  previous_ff [NUM_CHANNELS];
   logic            active_ff   [NUM_CHANNELS];
   logic [W_W-1:0]  held_ff     [NUM_CHANNELS];
   logic [W_W-1:0]  part_ff     [NUM_CHANNELS];
   logic [W_W-1:0]  act_ff      [NUM_CHANNELS];

   logic [CH_W-1:0] a_idx;
   logic [E_W:0]    a_sum;
   logic [E_W-1:0]  energy_in;
   logic [cad_pkg::RSP_PTR_W+1:0] credit_use;

   logic            a_valid_ff;
   logic [2:0]      a_ch_ff;
   logic [E_W-1:0]  a_e_ff;
   logic [E_W-1:0]  a_p_ff;

   logic            b_valid_ff;
   logic [2:0]      b_ch_ff;
   logic [E_W-1:0]  b_e_ff;
   logic [E_W-1:0]  b_p_ff;
   logic [P_W-1:0]  b_et_ff;
   logic [P_W-1:0]  b_pt_ff;

   logic [CH_W-1:0] c_idx;
   logic            fall;
   logic            rise;
   logic            active_in;
   logic [W_W-1:0]  held_in;
   logic [W_W-1:0]  part_in;
   logic [W_W-1:0]  act_in;
   logic [2:0]      event_in;
   logic [W_W-1:0]  part_number_in;
   logic [W_W-1:0]  flushed_in;

   // Results still in the pipeline hold a place in the result queue.
   assign credit_use = (cad_pkg::RSP_PTR_W + 2)'(rsp_level)
                     + (cad_pkg::RSP_PTR_W + 2)'(a_valid_ff)
                     + (cad_pkg::RSP_PTR_W + 2)'(b_valid_ff);
   assign work_pop = head.valid
                  && (credit_use < (cad_pkg::RSP_PTR_W + 2)'(cad_pkg::RSP_DEPTH));

   assign a_idx     = CH_W'(head.work.channel);
   assign a_sum     = {1'b0, energy_ff[a_idx]} + (E_W + 1)'(head.work.power);
   assign energy_in = a_sum[E_W] ? '1 : a_sum[E_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            energy_ff[i]   <= '0;
            previous_ff[i] <= '1;
         end
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= work_pop && head.work.last_bin;
         b_valid_ff <= a_valid_ff;
         if (work_pop) begin
            if (head.work.last_bin) begin
               energy_ff[a_idx]   <= '0;
               previous_ff[a_idx] <= energy_in;
            end else begin
               energy_ff[a_idx] <= energy_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ch_ff <= head.work.channel;
      a_e_ff  <= energy_in;
      a_p_ff  <= previous_ff[a_idx];
      b_ch_ff <= a_ch_ff;
      b_e_ff  <= a_e_ff;
      b_p_ff  <= a_p_ff;
      b_et_ff <= P_W'(a_e_ff) * P_W'(threshold_ratio);
      b_pt_ff <= P_W'(a_p_ff) * P_W'(threshold_ratio);
   end

   assign c_idx = CH_W'(b_ch_ff);
   assign fall  = P_W'({b_p_ff, 8'h00}) > b_et_ff;
   assign rise  = b_pt_ff < P_W'({b_e_ff, 8'h00});

   always_comb begin
      active_in      = active_ff[c_idx];
      held_in        = held_ff[c_idx];
      part_in        = part_ff[c_idx];
      act_in         = act_ff[c_idx];
      event_in       = cad_pkg::EV_IDLE;
      part_number_in = '0;
      flushed_in     = '0;
      priority if (active_ff[c_idx] && fall) begin
         active_in      = 1'b0;
         act_in         = act_ff[c_idx] + 1'b1;
         event_in       = cad_pkg::EV_DEACTIVATED;
         part_number_in = part_ff[c_idx];
         flushed_in     = held_ff[c_idx];
         held_in        = '0;
         part_in        = part_ff[c_idx] + 1'b1;
      end else if (!active_ff[c_idx] && rise) begin
         active_in = 1'b1;
         event_in  = cad_pkg::EV_ACTIVATED;
         held_in   = W_W'(2);
         part_in   = '0;
      end else if (active_ff[c_idx]) begin
         if (held_ff[c_idx] >= max_blocks) begin
            event_in       = cad_pkg::EV_PARTIAL;
            part_number_in = part_ff[c_idx];
            flushed_in     = held_ff[c_idx];
            held_in        = W_W'(1);
            part_in        = part_ff[c_idx] + 1'b1;
         end else begin
            event_in = cad_pkg::EV_APPEND;
            if (held_ff[c_idx] != '1) begin
               held_in = held_ff[c_idx] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            active_ff[i] <= 1'b0;
            held_ff[i]   <= '0;
            part_ff[i]   <= '0;
            act_ff[i]    <= '0;
         end
      end else if (b_valid_ff) begin
         active_ff[c_idx] <= active_in;
         held_ff[c_idx]   <= held_in;
         part_ff[c_idx]   <= part_in;
         act_ff[c_idx]    <= act_in;
      end
   end

   always_comb begin
      rsp_write.valid                 = b_valid_ff;
      rsp_write.item.out_channel      = b_ch_ff;
      rsp_write.item.event_res        = event_in;
      rsp_write.item.part_number      = part_number_in;
      rsp_write.item.activation_count = act_in;
      rsp_write.item.flushed_blocks   = flushed_in;
   end

endmodule

// File: sv/cad_rsp_queue.sv
module cad_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  cad_pkg::rsp_write_type        rsp_write,
   input  logic                          pop,
   output logic                          empty,
   output cad_pkg::rsp_item_type         rsp_item,
   output logic [cad_pkg::RSP_PTR_W:0]   level
);

   cad_pkg::rsp_item_type             queue_ff [cad_pkg::RSP_DEPTH];
   logic [cad_pkg::RSP_PTR_W-1:0]     wr_ptr_ff;
   logic [cad_pkg::RSP_PTR_W-1:0]     rd_ptr_ff;
   logic [cad_pkg::RSP_PTR_W:0]       count_ff;
   logic [cad_pkg::RSP_PTR_W:0]       count_in;
   logic                              read_en;

   assign empty   = count_ff == '0;
   assign read_en = pop && !empty;
   assign level   = count_ff;

   always_comb begin
      count_in = count_ff;
      if (rsp_write.valid && !read_en) begin
         count_in = count_ff + 1'b1;
      end else if (!rsp_write.valid && read_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (rsp_write.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (read_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_write.valid) begin
         queue_ff[wr_ptr_ff] <= rsp_write.item;
      end
   end

   assign rsp_item = queue_ff[rd_ptr_ff];

endmodule

// File: sv/cad_checker.sv
`include "channel_activity_detector_macros.svh"

module cad_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  empty,
   input logic                  pop,
   input cad_pkg::rsp_item_type rsp_item
);

   `CAD_ASSERT_ALWAYS(reset_clears_results, reset |=> empty)
   `CAD_ASSERT(no_flush_fields_zero, (!empty && (rsp_item.event_res == cad_pkg::EV_IDLE || rsp_item.event_res == cad_pkg::EV_ACTIVATED || rsp_item.event_res == cad_pkg::EV_APPEND)) |-> (rsp_item.part_number == '0 && rsp_item.flushed_blocks == '0))
   `CAD_ASSERT(flush_not_empty, (!empty && (rsp_item.event_res == cad_pkg::EV_DEACTIVATED || rsp_item.event_res == cad_pkg::EV_PARTIAL)) |-> rsp_item.flushed_blocks != '0)
   `CAD_ASSERT(stalled_result_holds, (!empty && !pop) |=> (!empty && $stable(rsp_item)))

endmodule

bind channel_activity_detector cad_checker u_cad_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int NUM_CH = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam logic [cad_pkg::CSR_INDEX_W-1:0] REG_SPARE = 8'd2;

   typedef enum {SENDER_SPARSE, RECEIVER_SPARSE, NO_IDLE} idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   cad_pkg::req_item_type req_item = '0;
   logic empty;
   logic pop = 1'b0;
   cad_pkg::rsp_item_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [cad_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [cad_pkg::WORD_W-1:0] csr_data = '0;

   cad_pkg::req_item_type bin_queue[$];
   cad_pkg::rsp_item_type expected_decisions[$];
   idle_mode_type idle_mode = SENDER_SPARSE;
   int mismatch_count = 0;
   int stall_cycles = 0;
   int hold_requests = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int window_level[NUM_CH];

   logic [cad_pkg::ENERGY_W-1:0] chan_energy[NUM_CH];
   logic [cad_pkg::ENERGY_W-1:0] chan_prev[NUM_CH];
   bit chan_active[NUM_CH];
   logic [15:0] chan_held[NUM_CH];
   logic [15:0] chan_part[NUM_CH];
   logic [15:0] chan_acts[NUM_CH];
   logic [15:0] ratio_cfg;
   logic [15:0] blocks_cfg;

   channel_activity_detector #(.NUM_CHANNELS(NUM_CH)) u_top (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_item(req_item),
      .empty(empty),
      .pop(pop),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int sender_idle_pct();
      case (idle_mode)
         SENDER_SPARSE: return 22;
         RECEIVER_SPARSE: return 52;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_mode)
         SENDER_SPARSE: return 52;
         RECEIVER_SPARSE: return 22;
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Accumulates one bin and, on the closing bin, works out the window's decision.
   function automatic void track_sample(input cad_pkg::req_item_type bin);
      logic [2:0] ch;
      logic signed [31:0] re_sq, im_sq;
      logic [31:0] pwr;
      logic [cad_pkg::ENERGY_W:0] acc;
      logic [cad_pkg::ENERGY_W-1:0] e, p;
      logic [63:0] p_ratio, e_ratio, p_unit, e_unit;
      cad_pkg::rsp_item_type d;
      ch = bin.channel_id;
      re_sq = $signed(bin.sample_re) * $signed(bin.sample_re);
      im_sq = $signed(bin.sample_im) * $signed(bin.sample_im);
      pwr = re_sq + im_sq;
      acc = chan_energy[ch] + pwr;
      e = acc[cad_pkg::ENERGY_W] ? '1 : acc[cad_pkg::ENERGY_W-1:0];
      chan_energy[ch] = e;
      if (!bin.last_bin)
         return;
      p = chan_prev[ch];
      p_ratio = p * ratio_cfg;
      e_ratio = e * ratio_cfg;
      p_unit = {p, 8'h00};
      e_unit = {e, 8'h00};
      d = '0;
      d.out_channel = ch;
      if (chan_active[ch] && p_unit > e_ratio) begin
         chan_active[ch] = 1'b0;
         chan_acts[ch] = chan_acts[ch] + 16'd1;
         d.event_res = cad_pkg::EV_DEACTIVATED;
         d.part_number = chan_part[ch];
         d.flushed_blocks = chan_held[ch];
         chan_held[ch] = '0;
         chan_part[ch] = chan_part[ch] + 16'd1;
      end else if (!chan_active[ch] && p_ratio < e_unit) begin
         chan_active[ch] = 1'b1;
         d.event_res = cad_pkg::EV_ACTIVATED;
         chan_held[ch] = 16'd2;
         chan_part[ch] = '0;
      end else if (chan_active[ch]) begin
         if (chan_held[ch] >= blocks_cfg) begin
            d.event_res = cad_pkg::EV_PARTIAL;
            d.part_number = chan_part[ch];
            d.flushed_blocks = chan_held[ch];
            chan_held[ch] = '0;
            chan_part[ch] = chan_part[ch] + 16'd1;
         end else begin
            d.event_res = cad_pkg::EV_APPEND;
         end
         if (chan_held[ch] != 16'hFFFF)
            chan_held[ch] = chan_held[ch] + 16'd1;
      end else begin
         d.event_res = cad_pkg::EV_IDLE;
      end
      d.activation_count = chan_acts[ch];
      chan_prev[ch] = e;
      chan_energy[ch] = '0;
      expected_decisions = {expected_decisions, d};
   endfunction

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   task automatic check_decision(input cad_pkg::rsp_item_type got);
      cad_pkg::rsp_item_type want;
      if (expected_decisions.size() == 0) begin
         report_mismatch($sformatf("decision for channel %0d with none pending",
                                   got.out_channel));
         return;
      end
      want = expected_decisions.pop_front();
      compare_field("out_channel", got.out_channel, want.out_channel);
      compare_field("event_res", got.event_res, want.event_res);
      compare_field("part_number", got.part_number, want.part_number);
      compare_field("activation_count", got.activation_count, want.activation_count);
      compare_field("flushed_blocks", got.flushed_blocks, want.flushed_blocks);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || !full) begin
         if (bin_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
            push <= 1'b1;
            req_item <= bin_queue.pop_front();
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= receiver_idle_pct());
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full)
            track_sample(req_item);
         if (pop && !empty)
            check_decision(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("channel_activity_detector: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic program_regs(input logic [15:0] ratio, input logic [15:0] limit_blocks);
      logic [cad_pkg::CSR_INDEX_W-1:0] idx[3];
      logic [cad_pkg::WORD_W-1:0] val[3];
      idx = '{REG_SPARE, cad_pkg::REG_THRESHOLD_RATIO, cad_pkg::REG_MAX_BLOCKS};
      val = '{16'($urandom), ratio, limit_blocks};
      @(posedge clock);
      csr_valid <= 1'b1;
      for (int k = 0; k < 3; k++) begin
         csr_index <= idx[k];
         csr_data <= val[k];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         if (idx[k] == cad_pkg::REG_THRESHOLD_RATIO)
            ratio_cfg = val[k];
         else if (idx[k] == cad_pkg::REG_MAX_BLOCKS)
            blocks_cfg = val[k];
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (bin_queue.size() != 0 || push || expected_decisions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void queue_bin(input logic [2:0] ch, input logic signed [15:0] re,
                                     input logic signed [15:0] im, input logic last);
      cad_pkg::req_item_type bin;
      bin.channel_id = ch;
      bin.sample_re = re;
      bin.sample_im = im;
      bin.last_bin = last;
      bin_queue = {bin_queue, bin};
   endfunction

   function automatic logic signed [15:0] scaled_sample(input int shift);
      logic signed [15:0] v;
      v = 16'($urandom);
      if (shift >= 16)
         return '0;
      return v >>> shift;
   endfunction

   // Each channel keeps a loudness level for a few windows, so decisions both
   // hold and swing across the threshold.
   function automatic void queue_random_bins(input int count);
      int ch;
      bit noisy;
      for (int n = 0; n < count; n++) begin
         ch = $urandom_range(NUM_CH - 1);
         noisy = ($urandom_range(99) < 10);
         queue_bin(3'(ch), scaled_sample(noisy ? 0 : window_level[ch]),
                   scaled_sample(noisy ? 0 : window_level[ch]),
                   $urandom_range(3) == 0);
         if (bin_queue[$].last_bin && $urandom_range(2) == 0)
            window_level[ch] = $urandom_range(16);
      end
   endfunction

   function automatic void queue_loud_window(input logic [2:0] ch, input int nbins);
      for (int n = 0; n < nbins; n++)
         queue_bin(ch, 16'sh8000, 16'sh8000, n == nbins - 1);
   endfunction

   initial begin
      logic [15:0] phase_ratio[6];
      logic [15:0] phase_blocks[6];
      for (int c = 0; c < NUM_CH; c++) begin
         chan_energy[c] = '0;
         chan_prev[c] = '1;
         chan_active[c] = 1'b0;
         chan_held[c] = '0;
         chan_part[c] = '0;
         chan_acts[c] = '0;
         window_level[c] = $urandom_range(16);
      end
      ratio_cfg = cad_pkg::THRESHOLD_RESET;
      blocks_cfg = cad_pkg::MAX_BLOCKS_RESET;
      phase_ratio = '{16'd511, 16'hFFFF, 16'd0, 16'd384, 16'd256, 16'($urandom_range(200, 700))};
      phase_blocks = '{16'd16, 16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The first window cannot activate, a silent window primes the next to activate.
      program_regs(16'd511, 16'd16);
      queue_bin(0, 16'sh8000, 16'sh8000, 1'b1);
      queue_bin(1, 16'sh7FFF, 16'sh7FFF, 1'b0);
      queue_bin(1, 16'sh0000, 16'sh0000, 1'b1);
      queue_bin(0, 16'sh0000, 16'sh0000, 1'b1);
      queue_bin(0, 16'sh7FFF, 16'sh8000, 1'b1);
      queue_bin(0, 16'sh7FFF, 16'sh7FFF, 1'b1);
      queue_bin(0, 16'sh0001, 16'sh0000, 1'b1);
      queue_bin(0, 16'sh0000, 16'sh0001, 1'b0);
      queue_bin(0, 16'shFFFF, 16'shFFFF, 1'b1);
      queue_bin(1, 16'sh5555, 16'shAAAA, 1'b1);
      wait_drained();

      // Zero ratio: any nonzero energy activates, even in the first window.
      program_regs(16'd0, 16'd0);
      queue_bin(2, 16'sh0000, 16'sh0001, 1'b1);
      queue_bin(2, 16'sh0000, 16'sh0001, 1'b1);
      queue_bin(2, 16'sh0000, 16'sh0000, 1'b1);
      queue_bin(2, 16'sh0000, 16'sh0000, 1'b1);
      wait_drained();

      // Unity ratio with zero max_blocks: every steady window flushes.
      program_regs(16'd256, 16'd0);
      queue_bin(4, 16'sh0000, 16'sh0000, 1'b1);
      queue_bin(4, 16'sh0005, 16'sh0005, 1'b1);
      queue_bin(4, 16'sh0005, 16'sh0005, 1'b1);
      queue_bin(4, 16'sh0005, 16'sh0005, 1'b1);
      queue_bin(4, 16'sh0005, 16'sh0005, 1'b1);
      queue_bin(4, 16'sh0000, 16'sh0000, 1'b1);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         idle_mode = (ph < 2) ? SENDER_SPARSE : (ph < 4) ? RECEIVER_SPARSE : NO_IDLE;
         program_regs(phase_ratio[ph], phase_blocks[ph]);
         if (ph == 1)
            hold_requests++;
         if (ph == 4)
            queue_loud_window(3, 520);
         queue_random_bins(140);
         wait_drained();
      end

      if (mismatch_count == 0 && expected_decisions.size() == 0) begin
         $display("channel_activity_detector: match");
      end else begin
         $display("channel_activity_detector: mismatch");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/cad_pkg.sv
sv/cad_front.sv
sv/cad_back.sv
sv/cad_rsp_queue.sv
sv/channel_activity_detector.sv
sv/cad_checker.sv
tb/tb.sv
